FILE: rtl/core/pglcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pglcd_pkg
// Shared constants and types of the paged graphic LCD controller.
// ----------------------------------------------------------------------------
package pglcd_pkg;

   localparam int unsigned COLUMNS_PER_HALF_DEF = 64;
   localparam int unsigned PAGE_COUNT_DEF       = 8;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned OP_W   = 2;
   localparam int unsigned LINE_W = 6;

   // bus operations
   localparam logic [OP_W-1:0] OP_INSTR = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // instruction codes
   localparam logic [BYTE_W-1:0] INSTR_DISPLAY_OFF = 8'h3E;
   localparam logic [BYTE_W-1:0] INSTR_DISPLAY_ON  = 8'h3F;
   localparam logic [BYTE_W-1:0] INSTR_CLASS_MASK  = 8'hC0;
   localparam logic [BYTE_W-1:0] INSTR_SET_COLUMN  = 8'h40;
   localparam logic [BYTE_W-1:0] INSTR_SET_LINE    = 8'hC0;
   localparam logic [BYTE_W-1:0] INSTR_PAGE_MASK   = 8'hF8;
   localparam logic [BYTE_W-1:0] INSTR_SET_PAGE    = 8'hB8;

   typedef struct packed {
      logic              instr;
      logic              write;
      logic              read;
      logic [BYTE_W-1:0] data;
   } pglcd_cmd_type;

   typedef struct packed {
      logic [BYTE_W-1:0] latch;
      logic              display_on;
      logic [LINE_W-1:0] first_line;
   } pglcd_stat_type;

endpackage
`default_nettype wire

FILE: rtl/core/pglcd_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pglcd_req_if
// Bus access channel: chip selects, operation and byte.
// ----------------------------------------------------------------------------
interface pglcd_req_if
   import pglcd_pkg::*;
;
   logic              valid;
   logic              ready;
   logic              select_left;
   logic              select_right;
   logic [OP_W-1:0]   operation;
   logic [BYTE_W-1:0] bus_byte;

   modport source (
      output valid, select_left, select_right, operation, bus_byte,
      input  ready
   );
   modport sink (
      input  valid, select_left, select_right, operation, bus_byte,
      output ready
   );
endinterface
`default_nettype wire

FILE: rtl/core/pglcd_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pglcd_rsp_if
// Result channel: read data and status of both halves.
// ----------------------------------------------------------------------------
interface pglcd_rsp_if
   import pglcd_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] read_data;
   logic              left_display_on;
   logic              right_display_on;
   logic [LINE_W-1:0] left_first_line;
   logic [LINE_W-1:0] right_first_line;

   modport source (
      output valid, read_data, left_display_on, right_display_on,
             left_first_line, right_first_line,
      input  ready
   );
   modport sink (
      input  valid, read_data, left_display_on, right_display_on,
             left_first_line, right_first_line,
      output ready
   );
endinterface
`default_nettype wire

FILE: rtl/core/pglcd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pglcd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pglcd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/pglcd_half.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pglcd_half
// One display half: address counters, start line, enable flag, output
// latch and the half's display memory.
// ----------------------------------------------------------------------------
module pglcd_half
   import pglcd_pkg::*;
#(
   parameter int unsigned COLUMNS_PER_HALF = COLUMNS_PER_HALF_DEF,
   parameter int unsigned PAGE_COUNT       = PAGE_COUNT_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire pglcd_cmd_type  cmd,
   output pglcd_stat_type      stat
);

   localparam int unsigned COL_W  = $clog2(COLUMNS_PER_HALF);
   localparam int unsigned PAGE_W = $clog2(PAGE_COUNT);
   localparam int unsigned DEPTH  = COLUMNS_PER_HALF * PAGE_COUNT;

   logic [COL_W-1:0]  col_ff,  col_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic              on_ff,   on_in;
   logic [BYTE_W-1:0] latch_ff, latch_in;
   logic              pending_ff, pending_in;
   logic [BYTE_W-1:0] ram_rdata;
   logic [BYTE_W-1:0] latch_now;
   logic [COL_W+PAGE_W-1:0] cell_addr;

   assign cell_addr = {page_ff, col_ff};

   pglcd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (cell_addr),
      .wr_data (cmd.data),
      .rd_en   (cmd.read),
      .rd_addr (cell_addr),
      .rd_data (ram_rdata)
   );

   // latch byte lands in the RAM output register in the cycle after a read
   assign latch_now = pending_ff ? ram_rdata : latch_ff;

   always_comb begin
      col_in     = col_ff;
      page_in    = page_ff;
      line_in    = line_ff;
      on_in      = on_ff;
      latch_in   = latch_ff;
      pending_in = pending_ff;
      if (cmd.instr) begin
         priority if (cmd.data == INSTR_DISPLAY_OFF || cmd.data == INSTR_DISPLAY_ON) begin
            on_in = cmd.data[0];
         end else if ((cmd.data & INSTR_CLASS_MASK) == INSTR_SET_COLUMN) begin
            col_in = cmd.data[COL_W-1:0];
         end else if ((cmd.data & INSTR_PAGE_MASK) == INSTR_SET_PAGE) begin
            page_in = cmd.data[PAGE_W-1:0];
         end else if ((cmd.data & INSTR_CLASS_MASK) == INSTR_SET_LINE) begin
            line_in = cmd.data[LINE_W-1:0];
         end else begin
            on_in = on_ff;
         end
      end else if (cmd.write || cmd.read) begin
         col_in = col_ff + COL_W'(1);
      end
      if (cmd.read) begin
         latch_in   = latch_now;
         pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         page_ff    <= '0;
         line_ff    <= '0;
         on_ff      <= 1'b0;
         latch_ff   <= '0;
         pending_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         page_ff    <= page_in;
         line_ff    <= line_in;
         on_ff      <= on_in;
         latch_ff   <= latch_in;
         pending_ff <= pending_in;
      end
   end

   assign stat.latch      = latch_now;
   assign stat.display_on = on_in;
   assign stat.first_line = line_in;

`ifndef NO_ASSERTIONS
   a_one_access : assert property (@(posedge clock)
      $countones({cmd.instr, cmd.write, cmd.read}) <= 1)
      else $error("more than one access kind on a half");

   a_col_advance : assert property (@(posedge clock) disable iff (reset)
      (cmd.write || cmd.read) |=> col_ff == COL_W'($past(col_ff) + COL_W'(1)))
      else $error("column did not advance after a data transfer");

   a_read_pending : assert property (@(posedge clock) disable iff (reset)
      cmd.read |=> pending_ff)
      else $error("latch load not pending after a read");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/paged_glcd_controller_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// paged_glcd_controller_top
// Two-half paged monochrome graphic LCD controller.
// ----------------------------------------------------------------------------
// One bus access is taken per clock cycle while the result register is free
// or being emptied; its result is registered and shown in the next cycle. Each
// half owns a display memory of PAGE_COUNT x COLUMNS_PER_HALF bytes with one
// write and one read port, so a data write to both halves completes in the
// same cycle. A data read returns the output latch and issues a memory read;
// the byte arrives in the memory output register the next cycle and is used
// as the latch from then on, so back-to-back reads run at full rate. Display
// memory is not cleared at reset and holds unknown data until written.
module paged_glcd_controller_top
   import pglcd_pkg::*;
#(
   parameter int unsigned COLUMNS_PER_HALF = COLUMNS_PER_HALF_DEF,
   parameter int unsigned PAGE_COUNT       = PAGE_COUNT_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pglcd_req_if.sink   req_bus,
   pglcd_rsp_if.source rsp_bus
);

   logic              req_fire;
   logic              is_instr, is_write, is_read;
   pglcd_cmd_type     left_cmd, right_cmd;
   pglcd_stat_type    left_stat, right_stat;
   logic [BYTE_W-1:0] rd_byte;

   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_data_ff;
   logic              rsp_left_on_ff, rsp_right_on_ff;
   logic [LINE_W-1:0] rsp_left_line_ff, rsp_right_line_ff;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign is_instr = req_fire && req_bus.operation == OP_INSTR;
   assign is_write = req_fire && req_bus.operation == OP_WRITE;
   assign is_read  = req_fire && req_bus.operation == OP_READ
                     && (req_bus.select_left || req_bus.select_right);

   assign left_cmd.instr  = is_instr && req_bus.select_left;
   assign left_cmd.write  = is_write && req_bus.select_left;
   assign left_cmd.read   = is_read && req_bus.select_left;
   assign left_cmd.data   = req_bus.bus_byte;
   assign right_cmd.instr = is_instr && req_bus.select_right;
   assign right_cmd.write = is_write && req_bus.select_right;
   assign right_cmd.read  = is_read && !req_bus.select_left;
   assign right_cmd.data  = req_bus.bus_byte;

   pglcd_half #(
      .COLUMNS_PER_HALF (COLUMNS_PER_HALF),
      .PAGE_COUNT       (PAGE_COUNT)
   ) u_left (
      .clock (clock),
      .reset (reset),
      .cmd   (left_cmd),
      .stat  (left_stat)
   );

   pglcd_half #(
      .COLUMNS_PER_HALF (COLUMNS_PER_HALF),
      .PAGE_COUNT       (PAGE_COUNT)
   ) u_right (
      .clock (clock),
      .reset (reset),
      .cmd   (right_cmd),
      .stat  (right_stat)
   );

   always_comb begin
      rd_byte = '0;
      if (is_read) begin
         rd_byte = req_bus.select_left ? left_stat.latch : right_stat.latch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff       <= rd_byte;
         rsp_left_on_ff    <= left_stat.display_on;
         rsp_right_on_ff   <= right_stat.display_on;
         rsp_left_line_ff  <= left_stat.first_line;
         rsp_right_line_ff <= right_stat.first_line;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.read_data        = rsp_data_ff;
   assign rsp_bus.left_display_on  = rsp_left_on_ff;
   assign rsp_bus.right_display_on = rsp_right_on_ff;
   assign rsp_bus.left_first_line  = rsp_left_line_ff;
   assign rsp_bus.right_first_line = rsp_right_line_ff;

`ifndef NO_ASSERTIONS
   a_single_reader : assert property (@(posedge clock)
      !(left_cmd.read && right_cmd.read))
      else $error("both halves read on one transfer");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result register not empty after reset");

   a_zero_data : assert property (@(posedge clock) disable iff (reset)
      (req_fire && !is_read) |=> rsp_data_ff == '0)
      else $error("non-read transfer returned data");

   a_fire_fills : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted access produced no result");
`endif

endmodule
`default_nettype wire
